// ===== sv/dcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types, codes, reset values and helper functions for the drive
// command mapper.
// ----------------------------------------------------------------------------
package dcm_pkg;

   localparam int FIELD_W         = 16;
   localparam int UNIT_W          = 15;
   localparam int CSR_INDEX_W     = 3;
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam logic [UNIT_W-1:0] UNIT_ONE       = 15'd16384;
   localparam logic [UNIT_W-1:0] DRIVE_DEADBAND = 15'd492;
   localparam logic [UNIT_W-1:0] BACK_DEADBAND  = 15'd492;
   localparam logic [UNIT_W-1:0] STOP_DEADBAND  = 15'd492;

   typedef enum logic {
      OP_STORE = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_SPEED   = 2'd0,
      MODE_BRAKE   = 2'd1,
      MODE_NEUTRAL = 2'd2
   } drive_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FWD_LIMIT   = 3'd0,
      CSR_REV_LIMIT   = 3'd1,
      CSR_BRAKE_LIMIT = 3'd2,
      CSR_STEER_GAIN  = 3'd3,
      CSR_STEER_CTR   = 3'd4,
      CSR_STEER_LOW   = 3'd5,
      CSR_STEER_HIGH  = 3'd6,
      CSR_STALE       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_W-1:0]        fwd_limit;
      logic [FIELD_W-1:0]        rev_limit;
      logic [FIELD_W-1:0]        brake_limit;
      logic signed [FIELD_W-1:0] steer_gain;
      logic [FIELD_W-1:0]        steer_center;
      logic [FIELD_W-1:0]        steer_low;
      logic [FIELD_W-1:0]        steer_high;
      logic [FIELD_W-1:0]        stale_after;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      fwd_limit:    16'd14000,
      rev_limit:    16'd5000,
      brake_limit:  16'd20000,
      steer_gain:   -16'sd5161,
      steer_center: 16'd34760,
      steer_low:    16'd9830,
      steer_high:   16'd55706,
      stale_after:  16'd25
   };

   typedef struct packed {
      logic                      neutral;
      logic signed [FIELD_W-1:0] steer;
      logic signed [FIELD_W-1:0] drive;
      logic signed [FIELD_W-1:0] back;
      logic signed [FIELD_W-1:0] stop;
   } job_type;

   function automatic logic signed [FIELD_W-1:0] clamp_steer(
      input logic signed [FIELD_W-1:0] v);
      logic signed [FIELD_W-1:0] r;
      if (v < -16'sd16384) begin
         r = -16'sd16384;
      end else if (v > 16'sd16384) begin
         r = 16'sd16384;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [UNIT_W-1:0] clamp_unit(
      input logic signed [FIELD_W-1:0] v);
      logic [UNIT_W-1:0] r;
      if (v[FIELD_W-1]) begin
         r = '0;
      end else if (v > 16'sd16384) begin
         r = UNIT_ONE;
      end else begin
         r = v[UNIT_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [UNIT_W-1:0] gate_band(
      input logic [UNIT_W-1:0] v,
      input logic [UNIT_W-1:0] band);
      return (v > band) ? v : '0;
   endfunction

endpackage

// ===== sv/dcm_if.sv =====
// ----------------------------------------------------------------------------
// dcm_if
// Valid/ready channels carrying the command words in and the result words out.
// ----------------------------------------------------------------------------
interface dcm_req_if;
   import dcm_pkg::*;

   logic                      valid;
   logic                      ready;
   opcode_type                opcode;
   logic signed [FIELD_W-1:0] steer_cmd;
   logic signed [FIELD_W-1:0] drive_cmd;
   logic signed [FIELD_W-1:0] back_cmd;
   logic signed [FIELD_W-1:0] stop_cmd;

   modport source (
      output valid, opcode, steer_cmd, drive_cmd, back_cmd, stop_cmd,
      input  ready
   );

   modport sink (
      input  valid, opcode, steer_cmd, drive_cmd, back_cmd, stop_cmd,
      output ready
   );
endinterface

interface dcm_rsp_if;
   import dcm_pkg::*;

   logic                      valid;
   logic                      ready;
   drive_mode_type            drive_mode;
   logic signed [FIELD_W:0]   motor_speed;
   logic [FIELD_W-1:0]        brake_current;
   logic [FIELD_W-1:0]        servo_setting;

   modport source (
      output valid, drive_mode, motor_speed, brake_current, servo_setting,
      input  ready
   );

   modport sink (
      input  valid, drive_mode, motor_speed, brake_current, servo_setting,
      output ready
   );
endinterface

// ===== sv/dcm_front.sv =====
// ----------------------------------------------------------------------------
// dcm_front
// Accepts command words, holds the latest command, ages it on each tick and
// queues a classified job for every tick.
// ----------------------------------------------------------------------------
module dcm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [dcm_pkg::FIELD_W-1:0] stale_after,
   dcm_req_if.sink                   req_ch,
   output logic                      push_valid,
   output dcm_pkg::job_type          push_job,
   input  logic                      push_ready
);
   import dcm_pkg::*;

   logic                      held_ff, held_in;
   logic [FIELD_W-1:0]        age_ff, age_in;
   logic signed [FIELD_W-1:0] steer_ff, steer_in;
   logic signed [FIELD_W-1:0] drive_ff, drive_in;
   logic signed [FIELD_W-1:0] back_ff, back_in;
   logic signed [FIELD_W-1:0] stop_ff, stop_in;
   logic                      accept;
   logic                      is_tick;
   logic [FIELD_W-1:0]        age_next;

   always_comb begin
      accept       = req_ch.valid && push_ready;
      req_ch.ready = push_ready;
      is_tick      = (req_ch.opcode == OP_TICK);
      age_next     = (age_ff == '1) ? age_ff : age_ff + 16'd1;

      push_valid       = accept && is_tick;
      push_job.neutral = !held_ff || (age_next > stale_after);
      push_job.steer   = steer_ff;
      push_job.drive   = drive_ff;
      push_job.back    = back_ff;
      push_job.stop    = stop_ff;
   end

   always_comb begin
      held_in  = held_ff;
      age_in   = age_ff;
      steer_in = steer_ff;
      drive_in = drive_ff;
      back_in  = back_ff;
      stop_in  = stop_ff;
      if (accept) begin
         if (is_tick) begin
            age_in = age_next;
         end else begin
            held_in  = 1'b1;
            age_in   = '0;
            steer_in = req_ch.steer_cmd;
            drive_in = req_ch.drive_cmd;
            back_in  = req_ch.back_cmd;
            stop_in  = req_ch.stop_cmd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         age_ff  <= '0;
      end else begin
         held_ff <= held_in;
         age_ff  <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      steer_ff <= steer_in;
      drive_ff <= drive_in;
      back_ff  <= back_in;
      stop_ff  <= stop_in;
   end

endmodule

// ===== sv/dcm_queue.sv =====
// ----------------------------------------------------------------------------
// dcm_queue
// Short job queue between the front and back halves.
// ----------------------------------------------------------------------------
module dcm_queue #(
   parameter int DEPTH = dcm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  dcm_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dcm_pkg::job_type pop_job
);
   import dcm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      push_ready = (count_ff != CNT_W'(DEPTH));
      pop_valid  = (count_ff != '0);
      pop_job    = entry_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/dcm_back.sv =====
// ----------------------------------------------------------------------------
// dcm_back
// Turns a queued job into speed, brake and servo values and holds the result
// word until the receiver takes it.
// ----------------------------------------------------------------------------
module dcm_back (
   input  logic             clock,
   input  logic             reset,
   input  dcm_pkg::cfg_type cfg,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  dcm_pkg::job_type pop_job,
   dcm_rsp_if.source        rsp_ch
);
   import dcm_pkg::*;

   logic                      out_valid_ff, out_valid_in;
   drive_mode_type            mode_ff, mode_in;
   logic signed [FIELD_W:0]   speed_ff, speed_in;
   logic [FIELD_W-1:0]        brake_ff, brake_in;
   logic [FIELD_W-1:0]        servo_ff, servo_in;
   logic                      load;

   logic signed [FIELD_W-1:0] steer_c;
   logic [UNIT_W-1:0]         drive_g;
   logic [UNIT_W-1:0]         back_g;
   logic [UNIT_W-1:0]         stop_g;
   logic                      brake_on;
   logic                      go_fwd;
   logic [UNIT_W-1:0]         mul_val;
   logic [FIELD_W-1:0]        mul_lim;
   logic [30:0]               scale_prod;
   logic [30:0]               scale_sum;
   logic [FIELD_W-1:0]        mag;
   logic signed [31:0]        servo_prod;
   logic signed [31:0]        servo_rnd;
   logic signed [19:0]        servo_sum;
   logic [FIELD_W-1:0]        lim_lo;
   logic [FIELD_W-1:0]        lim_hi;

   always_comb begin
      steer_c  = clamp_steer(pop_job.steer);
      drive_g  = gate_band(clamp_unit(pop_job.drive), DRIVE_DEADBAND);
      back_g   = gate_band(clamp_unit(pop_job.back), BACK_DEADBAND);
      stop_g   = gate_band(clamp_unit(pop_job.stop), STOP_DEADBAND);
      brake_on = (stop_g != '0);
      go_fwd   = (drive_g >= back_g);

      if (brake_on) begin
         mul_val = stop_g;
         mul_lim = cfg.brake_limit;
      end else if (go_fwd) begin
         mul_val = drive_g;
         mul_lim = cfg.fwd_limit;
      end else begin
         mul_val = back_g;
         mul_lim = cfg.rev_limit;
      end
      scale_prod = 31'(mul_val) * 31'(mul_lim);
      scale_sum  = scale_prod + 31'd8192;
      mag        = scale_sum[29:14];

      servo_prod = steer_c * cfg.steer_gain;
      servo_rnd  = servo_prod + 32'sd2048;
      servo_sum  = $signed({4'b0000, cfg.steer_center}) + $signed(servo_rnd[31:12]);
      lim_lo     = (cfg.steer_low < cfg.steer_high) ? cfg.steer_low : cfg.steer_high;
      lim_hi     = (cfg.steer_low < cfg.steer_high) ? cfg.steer_high : cfg.steer_low;
   end

   always_comb begin
      pop_ready = !out_valid_ff || rsp_ch.ready;
      load      = pop_valid && pop_ready;
      out_valid_in = pop_ready ? pop_valid : out_valid_ff;

      if (pop_job.neutral) begin
         mode_in  = MODE_NEUTRAL;
         speed_in = '0;
         brake_in = '0;
         servo_in = cfg.steer_center;
      end else begin
         if (brake_on) begin
            mode_in  = MODE_BRAKE;
            speed_in = '0;
            brake_in = mag;
         end else begin
            mode_in  = MODE_SPEED;
            brake_in = '0;
            speed_in = go_fwd ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
         end
         if (servo_sum < $signed({4'b0000, lim_lo})) begin
            servo_in = lim_lo;
         end else if (servo_sum > $signed({4'b0000, lim_hi})) begin
            servo_in = lim_hi;
         end else begin
            servo_in = servo_sum[FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mode_ff  <= mode_in;
         speed_ff <= speed_in;
         brake_ff <= brake_in;
         servo_ff <= servo_in;
      end
   end

   always_comb begin
      rsp_ch.valid         = out_valid_ff;
      rsp_ch.drive_mode    = mode_ff;
      rsp_ch.motor_speed   = speed_ff;
      rsp_ch.brake_current = brake_ff;
      rsp_ch.servo_setting = servo_ff;
   end

endmodule

// ===== sv/drive_command_mapper.sv =====
// ----------------------------------------------------------------------------
// drive_command_mapper
// Holds the latest drive command and maps it to speed, brake and servo words
// on each output tick.
//
// req_ch takes command words: a store word latches steering, throttle, reverse
// and brake and gives no result; a tick word ages the held command and gives
// exactly one result word on rsp_ch (neutral when nothing is held or the
// command is stale). csr_we/csr_index/csr_wdata write the eight settings.
// The user must use them only while the block is idle, which is not enforced.
// A tick word's job is written into the queue when accepted, then into the
// back half's output register that drives rsp_ch. One word is accepted per
// cycle while req_ch.ready is high; req_ch.ready is the ready of a job queue,
// two entries deep by default, ahead of that output register, so it drops
// only when the queue is full behind a stalled rsp_ch.
// The back half does one scaling multiply and one servo multiply per cycle.
// Reset is synchronous: no command is held, the age clears, the queue and
// output register empty and the settings return to their defaults.
// ----------------------------------------------------------------------------
module drive_command_mapper #(
   parameter int QUEUE_DEPTH = dcm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [dcm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dcm_pkg::FIELD_W-1:0]     csr_wdata,
   dcm_req_if.sink                        req_ch,
   dcm_rsp_if.source                      rsp_ch
);
   import dcm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FWD_LIMIT:   cfg_in.fwd_limit    = csr_wdata;
            CSR_REV_LIMIT:   cfg_in.rev_limit    = csr_wdata;
            CSR_BRAKE_LIMIT: cfg_in.brake_limit  = csr_wdata;
            CSR_STEER_GAIN:  cfg_in.steer_gain   = $signed(csr_wdata);
            CSR_STEER_CTR:   cfg_in.steer_center = csr_wdata;
            CSR_STEER_LOW:   cfg_in.steer_low    = csr_wdata;
            CSR_STEER_HIGH:  cfg_in.steer_high   = csr_wdata;
            CSR_STALE:       cfg_in.stale_after  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dcm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .stale_after (cfg_ff.stale_after),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .push_ready  (push_ready)
   );

   dcm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   dcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_ch    (rsp_ch)
   );

endmodule
